// ===== rtl/pcs_pkg.sv =====
// shared types, widths and codes for the pool capacity select block
package pcs_pkg;

    // field and datapath widths, fixed by the field ranges
    localparam int PAGE_W  = 17;
    localparam int MAXP_W  = 11;
    localparam int MIN_W   = 17;
    localparam int SLOT_W  = 21;
    localparam int LARGE_W = 28;   // max_pages * page_bytes
    localparam int PROD_W  = 38;   // slot * min_slots, count * slot
    localparam int DIV_W   = 38;   // shared divider operand width
    localparam int COUNT_W = 28;   // widest count before saturation
    localparam int MUL_AW  = 28;
    localparam int MUL_BW  = 21;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_PAGE = 2'd0;
    localparam logic [1:0] REG_MAXP = 2'd1;
    localparam logic [1:0] REG_MIN  = 2'd2;

    // register reset values
    localparam logic [PAGE_W-1:0] PAGE_RST = PAGE_W'(4096);
    localparam logic [MAXP_W-1:0] MAXP_RST = MAXP_W'(16);
    localparam logic [MIN_W-1:0]  MIN_RST  = MIN_W'(16);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LARGEST,
        S_PMIN,
        S_DECIDE,
        S_GCD,
        S_GCD_WAIT,
        S_CNT_WAIT,
        S_SPAN,
        S_SPAN_CMP,
        S_OVER_WAIT,
        S_FITS_WAIT,
        S_FITS_MUL,
        S_MOD_WAIT,
        S_TOP_WAIT,
        S_SAT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

// ===== rtl/pcs_div.sv =====
// restoring radix-2 divider, one quotient bit per cycle
module pcs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcs_pkg::t_div_req  i_req,
    output pcs_pkg::t_div_rsp  o_rsp
);

    localparam int W      = pcs_pkg::DIV_W;
    localparam int STEP_W = $clog2(W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_quot;
    logic [W-1:0]      r_dvs;

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         fits;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_quot;

    always_comb begin
        shifted = {r_rem, r_quot[W-1]};
        diff    = shifted - {1'b0, r_dvs};
        fits    = ~diff[W];
        n_rem   = fits ? diff[W-1:0] : shifted[W-1:0];
        n_quot  = {r_quot[W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quot <= i_req.dividend;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/pool_capacity_select_core.sv =====
// top level of the pool capacity select block: registers, sequencer, multiplier, divider
//
//  channel   direction  signals                                  transaction when
//  ------------------------------------------------------------------------------------
//  input     in         i_in_valid, o_in_stall, i_slot_bytes     i_in_valid & !o_in_stall
//  output    out        o_out_valid, i_out_stall, o_slot_count   o_out_valid & !i_out_stall
//  config    in/out     psel, penable, pwrite, paddr, pwdata,    psel & penable & pwrite
//                       prdata, pready                           & pready
//
// the time for one slot size is set by the shared 38-bit divider, used once per gcd step
// plus up to two further divisions; a zero slot size needs no division at all
// reset is synchronous, active low, and restores the register defaults
// o_in_stall is high from acceptance until the result is loaded into the output register
// a result waiting under i_out_stall holds the sequencer in its final state only;
// no new slot size is taken meanwhile, since o_in_stall stays high
module pool_capacity_select_core #(
    parameter int SIZE_BITS = 27
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input transactions
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [pcs_pkg::SLOT_W-1:0]   i_slot_bytes,
    // output transactions
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [SIZE_BITS-1:0]         o_slot_count,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pcs_pkg::ADDR_W-1:0]   paddr,
    input  logic [pcs_pkg::DATA_W-1:0]   pwdata,
    output logic [pcs_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int XW = (SIZE_BITS > pcs_pkg::COUNT_W) ? SIZE_BITS : pcs_pkg::COUNT_W;

    // configuration registers
    logic [pcs_pkg::PAGE_W-1:0] r_page;
    logic [pcs_pkg::MAXP_W-1:0] r_maxp;
    logic [pcs_pkg::MIN_W-1:0]  r_min;

    // sequencer and datapath registers
    pcs_pkg::t_state             r_state, n_state;
    logic [pcs_pkg::SLOT_W-1:0]  r_slot, n_slot;
    logic [pcs_pkg::LARGE_W-1:0] r_largest, n_largest;
    logic [pcs_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic [pcs_pkg::SLOT_W-1:0]  r_a, n_a;
    logic [pcs_pkg::SLOT_W-1:0]  r_b, n_b;
    logic [pcs_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_out_valid;
    logic [SIZE_BITS-1:0]        r_out_count;

    // shared multiplier
    logic [pcs_pkg::MUL_AW-1:0]               mul_a;
    logic [pcs_pkg::MUL_BW-1:0]               mul_b;
    logic [pcs_pkg::MUL_AW+pcs_pkg::MUL_BW-1:0] mul_p;

    // shared divider
    pcs_pkg::t_div_req div_req;
    pcs_pkg::t_div_rsp div_rsp;

    // saturation
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] sat_lim;
    logic [XW-1:0] sat_cnt;
    logic          out_free;
    logic          cfg_wr;

    // -------------------------------------------------------------- configuration
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= pcs_pkg::PAGE_RST;
            r_maxp <= pcs_pkg::MAXP_RST;
            r_min  <= pcs_pkg::MIN_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                pcs_pkg::REG_PAGE: r_page <= pwdata[pcs_pkg::PAGE_W-1:0];
                pcs_pkg::REG_MAXP: r_maxp <= pwdata[pcs_pkg::MAXP_W-1:0];
                pcs_pkg::REG_MIN:  r_min  <= pwdata[pcs_pkg::MIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            pcs_pkg::REG_PAGE: prdata = pcs_pkg::DATA_W'(r_page);
            pcs_pkg::REG_MAXP: prdata = pcs_pkg::DATA_W'(r_maxp);
            pcs_pkg::REG_MIN:  prdata = pcs_pkg::DATA_W'(r_min);
            default:           prdata = '0;
        endcase
    end

    // -------------------------------------------------------------- shared units
    pcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // operand select for the one multiplier; every product lands in a register
    always_comb begin
        unique case (r_state)
            pcs_pkg::S_LARGEST: begin
                mul_a = pcs_pkg::MUL_AW'(r_maxp);
                mul_b = pcs_pkg::MUL_BW'(r_page);
            end
            pcs_pkg::S_PMIN: begin
                mul_a = pcs_pkg::MUL_AW'(r_min);
                mul_b = r_slot;
            end
            pcs_pkg::S_SPAN: begin
                mul_a = r_count;
                mul_b = r_slot;
            end
            pcs_pkg::S_FITS_MUL: begin
                mul_a = div_rsp.quot[pcs_pkg::MUL_AW-1:0];
                mul_b = r_count[pcs_pkg::MUL_BW-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // saturate at half the output range
    assign cnt_x    = XW'(r_count);
    assign sat_lim  = XW'(1) << (SIZE_BITS - 1);
    assign sat_cnt  = (cnt_x > sat_lim) ? sat_lim : cnt_x;
    assign out_free = ~r_out_valid | ~i_out_stall;

    // -------------------------------------------------------------- sequencer
    always_comb begin
        n_state          = r_state;
        n_slot           = r_slot;
        n_largest        = r_largest;
        n_prod           = r_prod;
        n_a              = r_a;
        n_b              = r_b;
        n_count          = r_count;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        unique case (r_state)
            pcs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_slot  = i_slot_bytes;
                    n_state = pcs_pkg::S_LARGEST;
                end
            end
            pcs_pkg::S_LARGEST: begin
                n_largest = mul_p[pcs_pkg::LARGE_W-1:0];
                n_state   = pcs_pkg::S_PMIN;
            end
            pcs_pkg::S_PMIN: begin
                n_prod  = mul_p[pcs_pkg::PROD_W-1:0];
                n_state = pcs_pkg::S_DECIDE;
            end
            pcs_pkg::S_DECIDE: begin
                priority if (r_slot == '0) begin
                    n_count = '0;
                    n_state = pcs_pkg::S_SAT;
                end else if (r_prod < pcs_pkg::PROD_W'(r_largest)) begin
                    // page-fitting path, start the gcd loop on page and slot
                    n_a     = pcs_pkg::SLOT_W'(r_page);
                    n_b     = r_slot;
                    n_state = pcs_pkg::S_GCD;
                end else begin
                    // minimum path, top up to fill the last page
                    n_count = pcs_pkg::COUNT_W'(r_min);
                    if (r_page == '0) begin
                        n_state = pcs_pkg::S_SAT;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = pcs_pkg::DIV_W'(r_prod);
                        div_req.divisor  = pcs_pkg::DIV_W'(r_page);
                        n_state          = pcs_pkg::S_MOD_WAIT;
                    end
                end
            end
            pcs_pkg::S_GCD: begin
                div_req.start = 1'b1;
                if (r_b == '0) begin
                    // gcd found in r_a: start count = page / gcd
                    div_req.dividend = pcs_pkg::DIV_W'(r_page);
                    div_req.divisor  = pcs_pkg::DIV_W'(r_a);
                    n_state          = pcs_pkg::S_CNT_WAIT;
                end else begin
                    div_req.dividend = pcs_pkg::DIV_W'(r_a);
                    div_req.divisor  = pcs_pkg::DIV_W'(r_b);
                    n_state          = pcs_pkg::S_GCD_WAIT;
                end
            end
            pcs_pkg::S_GCD_WAIT: begin
                if (div_rsp.done) begin
                    n_a     = r_b;
                    n_b     = div_rsp.rem[pcs_pkg::SLOT_W-1:0];
                    n_state = pcs_pkg::S_GCD;
                end
            end
            pcs_pkg::S_CNT_WAIT: begin
                if (div_rsp.done) begin
                    n_count = div_rsp.quot[pcs_pkg::COUNT_W-1:0];
                    n_state = pcs_pkg::S_SPAN;
                end
            end
            pcs_pkg::S_SPAN: begin
                n_prod  = mul_p[pcs_pkg::PROD_W-1:0];
                n_state = pcs_pkg::S_SPAN_CMP;
            end
            pcs_pkg::S_SPAN_CMP: begin
                priority if (r_prod > pcs_pkg::PROD_W'(r_largest)) begin
                    // overshoot: as many slots as fit the largest size
                    div_req.start    = 1'b1;
                    div_req.dividend = pcs_pkg::DIV_W'(r_largest);
                    div_req.divisor  = pcs_pkg::DIV_W'(r_slot);
                    n_state          = pcs_pkg::S_OVER_WAIT;
                end else if (r_prod < pcs_pkg::PROD_W'(r_largest)) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = pcs_pkg::DIV_W'(r_largest);
                    div_req.divisor  = pcs_pkg::DIV_W'(r_prod);
                    n_state          = pcs_pkg::S_FITS_WAIT;
                end else begin
                    n_state = pcs_pkg::S_SAT;
                end
            end
            pcs_pkg::S_OVER_WAIT: begin
                if (div_rsp.done) begin
                    n_count = div_rsp.quot[pcs_pkg::COUNT_W-1:0];
                    n_state = pcs_pkg::S_SAT;
                end
            end
            pcs_pkg::S_FITS_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot >= pcs_pkg::DIV_W'(2)) begin
                        n_state = pcs_pkg::S_FITS_MUL;
                    end else begin
                        n_state = pcs_pkg::S_SAT;
                    end
                end
            end
            pcs_pkg::S_FITS_MUL: begin
                n_count = mul_p[pcs_pkg::COUNT_W-1:0];
                n_state = pcs_pkg::S_SAT;
            end
            pcs_pkg::S_MOD_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem > pcs_pkg::DIV_W'(r_slot)) begin
                        // unused tail of the last page, in whole slots
                        div_req.start    = 1'b1;
                        div_req.dividend = pcs_pkg::DIV_W'(r_page) - div_rsp.rem;
                        div_req.divisor  = pcs_pkg::DIV_W'(r_slot);
                        n_state          = pcs_pkg::S_TOP_WAIT;
                    end else begin
                        n_state = pcs_pkg::S_SAT;
                    end
                end
            end
            pcs_pkg::S_TOP_WAIT: begin
                if (div_rsp.done) begin
                    n_count = r_count + div_rsp.quot[pcs_pkg::COUNT_W-1:0];
                    n_state = pcs_pkg::S_SAT;
                end
            end
            pcs_pkg::S_SAT: begin
                if (out_free) begin
                    n_state = pcs_pkg::S_IDLE;
                end
            end
            default: n_state = pcs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot    <= n_slot;
        r_largest <= n_largest;
        r_prod    <= n_prod;
        r_a       <= n_a;
        r_b       <= n_b;
        r_count   <= n_count;
    end

    // -------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == pcs_pkg::S_SAT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == pcs_pkg::S_SAT) && out_free) begin
            r_out_count <= sat_cnt[SIZE_BITS-1:0];
        end
    end

    assign o_in_stall   = (r_state != pcs_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_slot_count = r_out_count;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for pool_capacity_select_core: directed table, random phases, scoreboard
module tb_top;

    localparam int CNT_W = 27;
    localparam longint unsigned COUNT_CAP = 64'd1 << (CNT_W - 1);
    // limit for the whole run, set well above the slowest run that the items and waits can make
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 175;
    localparam int IDLE_MAX    = 18;
    localparam int TAIL_CYCLES = 1500;
    localparam int N_CASES     = 23;

    // one row of the directed table: register setting, slot size, and a hand-typed
    // expectation where the answer is obvious (known = 1), otherwise the predictor decides
    typedef struct packed {
        logic [pcs_pkg::PAGE_W-1:0] page;
        logic [pcs_pkg::MAXP_W-1:0] maxp;
        logic [pcs_pkg::MIN_W-1:0]  minsl;
        logic [pcs_pkg::SLOT_W-1:0] slot;
        logic                       known;
        logic [CNT_W-1:0]           count;
    } t_slot_case;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_stall;
    logic [pcs_pkg::SLOT_W-1:0]  i_slot_bytes = '0;
    logic                        o_out_valid;
    logic                        i_out_stall  = 1'b0;
    logic [CNT_W-1:0]            o_slot_count;
    logic                        psel         = 1'b0;
    logic                        penable      = 1'b0;
    logic                        pwrite       = 1'b0;
    logic [pcs_pkg::ADDR_W-1:0]  paddr        = '0;
    logic [pcs_pkg::DATA_W-1:0]  pwdata       = '0;
    logic [pcs_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    // register copy used by the predictor
    longint unsigned    cfg_page = pcs_pkg::PAGE_RST;
    longint unsigned    cfg_maxp = pcs_pkg::MAXP_RST;
    longint unsigned    cfg_min  = pcs_pkg::MIN_RST;

    logic [CNT_W-1:0]   slot_count_q [$];   // capacities still owed by the block
    logic [CNT_W-1:0]   owed_count;
    int                 fail_count   = 0;
    int                 cycle_count  = 0;
    int                 out_idle_max = IDLE_MAX;
    int                 out_hold     = 0;
    t_slot_case         slot_cases [N_CASES];

    pool_capacity_select_core #(
        .SIZE_BITS (CNT_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_slot_bytes (i_slot_bytes),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_slot_count (o_slot_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pool_capacity_select_core test failed");
            $finish;
        end
    end

    // capacity the block should choose for one slot size under the current registers
    function automatic logic [CNT_W-1:0] pool_slot_count(
        input logic [pcs_pkg::SLOT_W-1:0] slot_in);
        longint unsigned slot, largest, count, span, fits, used, a, b, r;
        slot    = slot_in;
        largest = cfg_maxp * cfg_page;
        if (slot == 0)
            return '0;
        if (slot * cfg_min < largest) begin
            // gcd loop: fewest slots that exactly fill whole pages
            a = cfg_page;
            b = slot;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            count = cfg_page / a;
            span  = count * slot;
            if (span > largest) begin
                count = largest / slot;
            end else if (span < largest) begin
                fits = largest / span;
                if (fits >= 2)
                    count = count * fits;
            end
        end else begin
            // minimum path, topped up to fill the last page when it is worth a slot
            count = cfg_min;
            if (cfg_page != 0) begin
                used = (cfg_min * slot) % cfg_page;
                if (used > slot)
                    count = count + (cfg_page - used) / slot;
            end
        end
        if (count > COUNT_CAP)
            count = COUNT_CAP;
        return count[CNT_W-1:0];
    endfunction

    // one apb transaction: setup phase, then access phase until pready
    task automatic apb_access(input bit wr, input logic [1:0] idx,
                              input logic [pcs_pkg::DATA_W-1:0] wdata,
                              output logic [pcs_pkg::DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // register read with comparison against the value it should hold
    task automatic check_reg(input logic [1:0] idx, input logic [pcs_pkg::DATA_W-1:0] want,
                             input string name);
        logic [pcs_pkg::DATA_W-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, rd);
            fail_count++;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input longint unsigned value,
                             input int width, input string name);
        logic [pcs_pkg::DATA_W-1:0] rd;
        logic [pcs_pkg::DATA_W-1:0] masked;
        masked = pcs_pkg::DATA_W'(value) & ((pcs_pkg::DATA_W'(1) << width) - 1);
        apb_access(1'b1, idx, pcs_pkg::DATA_W'(value), rd);
        check_reg(idx, masked, name);
    endtask

    task automatic set_config(input longint unsigned page, input longint unsigned maxp,
                              input longint unsigned minsl);
        write_reg(pcs_pkg::REG_PAGE, page, pcs_pkg::PAGE_W, "page_bytes");
        write_reg(pcs_pkg::REG_MAXP, maxp, pcs_pkg::MAXP_W, "max_pages");
        write_reg(pcs_pkg::REG_MIN, minsl, pcs_pkg::MIN_W, "min_slots");
        cfg_page = page & ((64'd1 << pcs_pkg::PAGE_W) - 1);
        cfg_maxp = maxp & ((64'd1 << pcs_pkg::MAXP_W) - 1);
        cfg_min  = minsl & ((64'd1 << pcs_pkg::MIN_W) - 1);
    endtask

    // present one slot size after a gap, hold it until the block takes it,
    // and record what the block owes for it
    task automatic send_slot(input logic [pcs_pkg::SLOT_W-1:0] slot, input int gap,
                             input logic known, input logic [CNT_W-1:0] count);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_slot_bytes = slot;
        do @(posedge i_clk); while (o_in_stall);
        slot_count_q.push_back(known ? count : pool_slot_count(slot));
    endtask

    // stop sending and let every owed capacity come back before touching registers
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (slot_count_q.size() != 0)
            @(posedge i_clk);
    endtask

    // slot sizes: mostly page-scale values, powers of two, and the full 21-bit field
    function automatic logic [pcs_pkg::SLOT_W-1:0] pick_slot();
        case ($urandom_range(0, 7))
            0:       return pcs_pkg::SLOT_W'(1) << $urandom_range(0, pcs_pkg::SLOT_W - 1);
            1:       return pcs_pkg::SLOT_W'($urandom_range(0, (1 << pcs_pkg::SLOT_W) - 1));
            2, 3:    return pcs_pkg::SLOT_W'($urandom_range(1, 4096));
            4:       return pcs_pkg::SLOT_W'($urandom_range(1, 64) << $urandom_range(0, 12));
            5:       return pcs_pkg::SLOT_W'($urandom_range(1, 1048576));
            6:       return pcs_pkg::SLOT_W'($urandom_range(1, 300));
            default: return pcs_pkg::SLOT_W'($urandom_range(0, 3));
        endcase
    endfunction

    // scoreboard: every result transaction against the oldest owed capacity
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (slot_count_q.size() == 0) begin
                $error("slot_count with nothing owed: actual %0d", o_slot_count);
                fail_count++;
            end else begin
                owed_count = slot_count_q.pop_front();
                if (o_slot_count !== owed_count) begin
                    $error("slot_count mismatch: expected %0d, actual %0d",
                           owed_count, o_slot_count);
                    fail_count++;
                end
            end
            out_hold = (out_idle_max > 0) ? $urandom_range(0, out_idle_max) : 0;
        end
    end

    // receiver back-pressure: a fresh wait drawn after each result transaction
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_stall = 1'b1;
            out_hold    = out_hold - 1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    initial begin
        longint unsigned page, maxp, minsl;
        int              in_idle_max;

        // directed cases: default registers first, then each special region of the choice
        slot_cases = '{
            '{4096,   16,   16,     0,       1, 0},          // zero slot size
            '{4096,   16,   16,     1,       0, 0},
            '{4096,   16,   16,     64,      0, 0},
            '{4096,   16,   16,     3000,    0, 0},          // start overshoots the pool
            '{4096,   16,   16,     5000,    0, 0},          // minimum path, no top-up
            '{4096,   16,   16,     1048576, 0, 0},
            '{4096,   16,   16,     2097151, 0, 0},          // all slot bits set
            '{4096,   1,    16,     300,     0, 0},          // minimum path with top-up
            '{6,      3,    1,      4,       0, 0},          // fits only once
            '{4096,   1,    1,      2048,    0, 0},          // span equals the pool
            '{4096,   3,    1,      2048,    0, 0},
            '{65536,  1024, 16,     1,       0, 0},          // lands exactly on the cap
            '{131071, 2047, 1,      1,       1, 67108864},   // saturates
            '{131071, 2047, 1,      2097151, 0, 0},
            '{0,      16,   16,     5,       1, 16},         // zero page size
            '{0,      16,   16,     0,       1, 0},
            '{4096,   0,    16,     100,     0, 0},          // zero page count
            '{4096,   16,   0,      100,     0, 0},          // zero minimum
            '{4096,   0,    0,      7,       1, 0},
            '{65536,  1024, 131071, 1,       0, 0},
            '{65536,  1024, 131071, 1048576, 0, 0},
            '{65536,  1024, 131071, 3,       0, 0},
            '{100,    1,    5,      33,      0, 0}
        };

        // synchronous reset, released on a falling clock edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults after reset
        check_reg(pcs_pkg::REG_PAGE, pcs_pkg::DATA_W'(pcs_pkg::PAGE_RST), "page_bytes");
        check_reg(pcs_pkg::REG_MAXP, pcs_pkg::DATA_W'(pcs_pkg::MAXP_RST), "max_pages");
        check_reg(pcs_pkg::REG_MIN, pcs_pkg::DATA_W'(pcs_pkg::MIN_RST), "min_slots");

        foreach (slot_cases[k]) begin
            if (slot_cases[k].page != cfg_page || slot_cases[k].maxp != cfg_maxp ||
                slot_cases[k].minsl != cfg_min) begin
                drain();
                set_config(slot_cases[k].page, slot_cases[k].maxp, slot_cases[k].minsl);
            end
            send_slot(slot_cases[k].slot, $urandom_range(0, IDLE_MAX),
                      slot_cases[k].known, slot_cases[k].count);
        end

        // random phases, each with its own register setting and idling pattern
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            case ($urandom_range(0, 5))
                0: begin
                    page  = 64'd1 << $urandom_range(0, 16);
                    maxp  = $urandom_range(1, 1024);
                    minsl = $urandom_range(1, 64);
                end
                1: begin
                    page  = $urandom_range(1, 65536);
                    maxp  = $urandom_range(1, 1024);
                    minsl = $urandom_range(1, 65536);
                end
                2: begin
                    // whole register fields, zero included
                    page  = $urandom_range(0, (1 << pcs_pkg::PAGE_W) - 1);
                    maxp  = $urandom_range(0, (1 << pcs_pkg::MAXP_W) - 1);
                    minsl = $urandom_range(0, (1 << pcs_pkg::MIN_W) - 1);
                end
                3: begin
                    page  = $urandom_range(1, 512);
                    maxp  = $urandom_range(1, 8);
                    minsl = $urandom_range(1, 32);
                end
                4: begin
                    case ($urandom_range(0, 3))
                        0:       page = 0;
                        1:       page = 1;
                        2:       page = 65536;
                        default: page = 131071;
                    endcase
                    case ($urandom_range(0, 3))
                        0:       maxp = 0;
                        1:       maxp = 1;
                        2:       maxp = 1024;
                        default: maxp = 2047;
                    endcase
                    case ($urandom_range(0, 3))
                        0:       minsl = 0;
                        1:       minsl = 1;
                        2:       minsl = 65536;
                        default: minsl = 131071;
                    endcase
                end
                default: begin
                    page  = pcs_pkg::PAGE_RST;
                    maxp  = pcs_pkg::MAXP_RST;
                    minsl = pcs_pkg::MIN_RST;
                end
            endcase
            set_config(page, maxp, minsl);

            // some phases run flat out on one or both sides
            in_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;

            for (int n = 0; n < PHASE_ITEMS; n++)
                send_slot(pick_slot(),
                          (in_idle_max > 0) ? $urandom_range(0, in_idle_max) : 0,
                          1'b0, '0);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && slot_count_q.size() == 0) begin
            $display("pool_capacity_select_core test passed");
        end else begin
            $display("pool_capacity_select_core test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pcs_pkg.sv
rtl/pcs_div.sv
rtl/pool_capacity_select_core.sv
tb/sv/tb_top.sv
